// File: design/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types and constants for the stream byte reassembler.
// ----------------------------------------------------------------------------
package tbr_pkg;

	localparam int TBR_CAPACITY = 1024;
	localparam int IDX_W        = 32;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 11;

	// Request function codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic              func;
		logic [IDX_W-1:0]  stream_index;
		logic [BYTE_W-1:0] byte_value;
		logic              has_byte;
		logic              end_of_stream;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              read_valid;
		logic [CNT_W-1:0]  held_count;
		logic [CNT_W-1:0]  fifo_count;
		logic              stream_ended;
	} rsp_t;

endpackage

// File: design/tbr_if.sv
// ----------------------------------------------------------------------------
// tbr_req_if / tbr_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface tbr_req_if
	import tbr_pkg::*;
	();
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tbr_rsp_if
	import tbr_pkg::*;
	();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/tbr_sdp_ram.sv
// ----------------------------------------------------------------------------
// tbr_sdp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tbr_sdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: design/tbr_ctrl.sv
// ----------------------------------------------------------------------------
// tbr_ctrl
// Sequencer: window ring read-modify-write, drain walk and FIFO bookkeeping.
// ----------------------------------------------------------------------------
module tbr_ctrl
	import tbr_pkg::*;
#(
	parameter int CAPACITY = TBR_CAPACITY,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  req_t              item,
	output logic              res_valid,
	input  logic              res_take,
	output rsp_t              res,
	output logic              ring_we,
	output logic [AW-1:0]     ring_waddr,
	output logic [BYTE_W:0]   ring_wdata,
	output logic [AW-1:0]     ring_raddr,
	input  logic [BYTE_W:0]   ring_rdata,
	output logic              fifo_we,
	output logic [AW-1:0]     fifo_waddr,
	output logic [BYTE_W-1:0] fifo_wdata,
	output logic [AW-1:0]     fifo_raddr,
	input  logic [BYTE_W-1:0] fifo_rdata
);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD1  = 4'd2;
	localparam logic [3:0] ST_RD2  = 4'd3;
	localparam logic [3:0] ST_P1   = 4'd4;
	localparam logic [3:0] ST_P2   = 4'd5;
	localparam logic [3:0] ST_D1   = 4'd6;
	localparam logic [3:0] ST_D2   = 4'd7;
	localparam logic [3:0] ST_P3   = 4'd8;
	localparam logic [3:0] ST_P4   = 4'd9;
	localparam logic [3:0] ST_CHK  = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;

	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
	localparam logic [AW:0]   CAP_EXT   = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

	logic [3:0]        st_q;
	req_t              item_q;
	logic [IDX_W-1:0]  ne_q;
	logic [AW-1:0]     wh_q;
	logic [CW-1:0]     held_q;
	logic [AW-1:0]     fh_q;
	logic [CW-1:0]     fill_q;
	logic              end_known_q;
	logic [IDX_W-1:0]  end_idx_q;
	logic              ended_q;
	logic              second_q;
	logic [AW-1:0]     clr_q;
	logic [BYTE_W-1:0] rbyte_q;
	logic              rvalid_q;

	logic [IDX_W-1:0] off;
	logic             in_win;
	logic [AW:0]      slot_sum;
	logic [AW-1:0]    slot;
	logic [AW-1:0]    wh_inc;
	logic [AW-1:0]    fh_inc;
	logic [AW:0]      tail_sum;
	logic [AW-1:0]    tail;
	logic             fifo_full;

	// Window offset and ring slot of the current byte
	assign off      = item_q.stream_index - ne_q;
	assign in_win   = off < IDX_W'(CAPACITY);
	assign slot_sum = {1'b0, wh_q} + {1'b0, off[AW-1:0]};
	assign slot     = (slot_sum >= CAP_EXT) ? AW'(slot_sum - CAP_EXT) : slot_sum[AW-1:0];
	assign wh_inc   = (wh_q == LAST_SLOT) ? '0 : wh_q + 1'b1;
	assign fh_inc   = (fh_q == LAST_SLOT) ? '0 : fh_q + 1'b1;
	assign tail_sum = {1'b0, fh_q} + (AW + 1)'(fill_q);
	assign tail     = (tail_sum >= CAP_EXT) ? AW'(tail_sum - CAP_EXT) : tail_sum[AW-1:0];
	assign fifo_full = (fill_q == CAP_CNT);

	assign item_ready = (st_q == ST_IDLE);
	assign res_valid  = (st_q == ST_FIN);
	assign fifo_raddr = fh_q;
	assign ring_raddr = (st_q == ST_D1) ? wh_q : slot;

	always_comb begin
		res.read_byte    = rbyte_q;
		res.read_valid   = rvalid_q;
		res.held_count   = CNT_W'(held_q);
		res.fifo_count   = CNT_W'(fill_q);
		res.stream_ended = ended_q;
	end

	// Memory write strobes per state
	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = slot;
		ring_wdata = {1'b1, item_q.byte_value};
		fifo_we    = 1'b0;
		fifo_waddr = tail;
		fifo_wdata = item_q.byte_value;
		case (st_q)
			ST_CLR: begin
				ring_we    = 1'b1;
				ring_waddr = clr_q;
				ring_wdata = '0;
			end
			ST_P2: begin
				ring_we = ring_rdata[BYTE_W] && in_win;
			end
			ST_D2: begin
				ring_we    = ring_rdata[BYTE_W];
				ring_waddr = wh_q;
				ring_wdata = '0;
				fifo_we    = ring_rdata[BYTE_W];
				fifo_wdata = ring_rdata[BYTE_W-1:0];
			end
			ST_P3: begin
				fifo_we = (off == '0) && !fifo_full;
			end
			ST_P4: begin
				ring_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			ne_q        <= '0;
			wh_q        <= '0;
			held_q      <= '0;
			fh_q        <= '0;
			fill_q      <= '0;
			end_known_q <= 1'b0;
			end_idx_q   <= '0;
			ended_q     <= 1'b0;
			second_q    <= 1'b0;
			clr_q       <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			case (st_q)
				// Sweep the ring clear after reset
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						st_q <= ST_IDLE;
					end
				end
				// Take a transaction, latch end mark
				ST_IDLE: begin
					if (item_valid) begin
						rvalid_q <= 1'b0;
						second_q <= 1'b0;
						if (item.func == FUNC_READ) begin
							st_q <= ST_RD1;
						end else begin
							if (item.end_of_stream) begin
								end_idx_q   <= item.stream_index + IDX_W'(item.has_byte);
								end_known_q <= 1'b1;
							end
							st_q <= item.has_byte ? ST_P1 : ST_CHK;
						end
					end
				end
				ST_RD1: begin
					st_q <= (fill_q == '0) ? ST_FIN : ST_RD2;
				end
				// Pop the head byte
				ST_RD2: begin
					rvalid_q <= 1'b1;
					fh_q     <= fh_inc;
					fill_q   <= fill_q - 1'b1;
					st_q     <= ST_FIN;
				end
				ST_P1: begin
					st_q <= in_win ? ST_P2 : ST_D1;
				end
				ST_P2: begin
					st_q <= ST_D1;
				end
				// Drain walk: check the head slot
				ST_D1: begin
					if (fifo_full) begin
						st_q     <= second_q ? ST_CHK : ST_P3;
						second_q <= 1'b1;
					end else begin
						st_q <= ST_D2;
					end
				end
				// Move a held byte into the FIFO and advance
				ST_D2: begin
					if (ring_rdata[BYTE_W]) begin
						fill_q <= fill_q + 1'b1;
						held_q <= held_q - 1'b1;
						ne_q   <= ne_q + 1'b1;
						wh_q   <= wh_inc;
						st_q   <= ST_D1;
					end else begin
						st_q     <= second_q ? ST_CHK : ST_P3;
						second_q <= 1'b1;
					end
				end
				// Place the byte: direct to FIFO, hold, or drop
				ST_P3: begin
					if (off == '0 && !fifo_full) begin
						fill_q <= fill_q + 1'b1;
						ne_q   <= ne_q + 1'b1;
						wh_q   <= wh_inc;
						st_q   <= ST_D1;
					end else if (in_win) begin
						st_q <= ST_P4;
					end else begin
						st_q <= ST_D1;
					end
				end
				ST_P4: begin
					if (!ring_rdata[BYTE_W]) begin
						held_q <= held_q + 1'b1;
					end
					st_q <= ST_D1;
				end
				ST_CHK: begin
					if (end_known_q && ne_q == end_idx_q) begin
						ended_q <= 1'b1;
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_take) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && item_valid) begin
			item_q  <= item;
			rbyte_q <= '0;
		end else if (st_q == ST_RD2) begin
			rbyte_q <= fifo_rdata;
		end
	end

endmodule

// File: design/tcp_byte_stream_reassembler_core.sv
// ----------------------------------------------------------------------------
// tcp_byte_stream_reassembler_core
// Out-of-order byte stream reassembler with in-order output FIFO.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. After
// reset the block sweeps its window ring clear before taking requests. A
// read pops the head byte when the FIFO holds one. A push with a byte also
// drains held bytes into the output FIFO; each drain step reads a window
// ring slot through its registered read port and then clears it. One
// request is in flight at a time. The next request is taken in the cycle
// after the response leaves the sequencer, and a finished response waits
// in an output register while the consumer stalls.
module tcp_byte_stream_reassembler_core
	import tbr_pkg::*;
#(
	parameter int CAPACITY = TBR_CAPACITY
) (
	input logic       clk,
	input logic       arst_n,
	tbr_req_if.sink   req,
	tbr_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic              res_valid;
	logic              res_take;
	rsp_t              res;
	logic              ring_we;
	logic [AW-1:0]     ring_waddr;
	logic [BYTE_W:0]   ring_wdata;
	logic [AW-1:0]     ring_raddr;
	logic [BYTE_W:0]   ring_rdata;
	logic              fifo_we;
	logic [AW-1:0]     fifo_waddr;
	logic [BYTE_W-1:0] fifo_wdata;
	logic [AW-1:0]     fifo_raddr;
	logic [BYTE_W-1:0] fifo_rdata;
	logic              rsp_v_q;
	rsp_t              rsp_q;

	tbr_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (req.valid),
		.item_ready (req.ready),
		.item       (req.payload),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.fifo_we    (fifo_we),
		.fifo_waddr (fifo_waddr),
		.fifo_wdata (fifo_wdata),
		.fifo_raddr (fifo_raddr),
		.fifo_rdata (fifo_rdata)
	);

	// Window ring: valid mark over data byte
	tbr_sdp_ram #(.WIDTH(BYTE_W + 1), .DEPTH(CAPACITY)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// In-order output FIFO storage
	tbr_sdp_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_fifo (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	// Output register: load when empty or being drained
	assign res_take    = !rsp_v_q || rsp.ready;
	assign rsp.valid   = rsp_v_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (res_take) begin
			rsp_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

endmodule
